>>> hdl/three_class_stable_priority_queue_assert.svh
// Assertion macros shared by the priority queue RTL.
`ifndef THREE_CLASS_STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define THREE_CLASS_STABLE_PRIORITY_QUEUE_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define TCSPQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define TCSPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/tcspq_pkg.sv
// Shared types, codes and helpers for the three-class priority queue.
`default_nettype none
package tcspq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int DEFAULT_ID_BITS     = 16;

   localparam int NUM_CLASSES = 3;
   localparam int CLS_IDX_W   = 2;
   localparam int REQ_TYPE_W  = 2;
   localparam int FIELD_ID_W  = 16;
   localparam int CLASS_W     = 2;
   localparam int STATUS_W    = 3;
   localparam int TDATA_W     = 24;

   localparam logic [CLASS_W-1:0] VIP          = 2'd1;
   localparam logic [CLASS_W-1:0] LOWEST_CLASS = 2'd3;
   localparam logic [CLASS_W-1:0] NO_CLASS     = 2'd0;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_ENQUEUE = 2'd0,
      REQ_DEQUEUE = 2'd1,
      REQ_LIST    = 2'd2,
      REQ_INVALID = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_ACCEPTED = 3'd0,
      STS_SERVED   = 3'd1,
      STS_LISTED   = 3'd2,
      STS_EMPTY    = 3'd3,
      STS_FULL     = 3'd4,
      STS_INVALID  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SERVE,
      S_LIST
   } state_type;

   typedef logic [CLS_IDX_W-1:0] cls_idx_type;

   // Map a class code to its region index; an unknown class falls to the lowest.
   function automatic cls_idx_type class_to_idx(input logic [CLASS_W-1:0] cls);
      logic [CLASS_W-1:0] eff;
      eff = (cls == NO_CLASS) ? LOWEST_CLASS : cls;
      return cls_idx_type'(eff - VIP);
   endfunction

   function automatic logic [CLASS_W-1:0] idx_to_class(input cls_idx_type idx);
      return CLASS_W'(idx) + VIP;
   endfunction

endpackage
`default_nettype wire

>>> hdl/tcspq_ram.sv
// Simple dual-port memory with registered read.
`default_nettype none
module tcspq_ram #(
   parameter int ADDR_W = 6,
   parameter int DATA_W = 16,
   parameter int DEPTH  = 48
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hdl/three_class_stable_priority_queue.sv
// Top level of the three-class stable priority queue.
`default_nettype none
`include "three_class_stable_priority_queue_assert.svh"
// Bounded priority queue of up to QUEUE_DEPTH entries, each an identifier and a
// class from 1 (highest) to 3 (lowest); class 0 is stored as class 3. Service
// order is all class 1 entries, then class 2, then class 3, first-in first-out
// within a class. The identifiers live in one memory split into three circular
// regions, one per class, with head, tail and count registers per class, so the
// class of an entry is implied by its region. A request carries its kind in
// req_tuser; every request produces one or more responses with a status in
// rsp_tuser and rsp_tlast on the final response of that request. An enqueue,
// an invalid request and an empty dequeue or list are answered from the
// request alone; a dequeue answers with the identifier from a registered read
// of the identifier memory; a list makes one memory read per stored entry
// through the single read port. One request is in work at a time. The
// response register decouples the two sides: a new request is taken in the
// cycle the previous response leaves. Back-pressure on rsp_tready holds the
// response, the next request and the next read of a list walk. No clearing pass
// follows reset; the memory is only read below each region's count.
module three_class_stable_priority_queue #(
   parameter int QUEUE_DEPTH = tcspq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int ID_BITS     = tcspq_pkg::DEFAULT_ID_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request channel.
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [15:0] entry_id, [17:16] entry_class, [23:18] zero
   input  wire logic [tcspq_pkg::TDATA_W-1:0]   req_tdata,
   // [1:0] req_type
   input  wire logic [tcspq_pkg::REQ_TYPE_W-1:0] req_tuser,
   // Response channel.
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [15:0] out_id, [17:16] out_class, [23:18] zero
   output logic      [tcspq_pkg::TDATA_W-1:0]   rsp_tdata,
   // [2:0] status
   output logic      [tcspq_pkg::STATUS_W-1:0]  rsp_tuser,
   output logic                                 rsp_tlast
);

   import tcspq_pkg::*;

   localparam int PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W      = (ID_BITS < FIELD_ID_W) ? ID_BITS : FIELD_ID_W;
   localparam int ADDR_W    = PTR_W + CLS_IDX_W;
   localparam int MEM_DEPTH = NUM_CLASSES << PTR_W;
   localparam int PAD_W     = TDATA_W - FIELD_ID_W - CLASS_W;

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   // Advance a region pointer, wrapping at the region size.
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   // Control registers.
   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   head_ff [NUM_CLASSES];
   logic [PTR_W-1:0]   head_in [NUM_CLASSES];
   logic [PTR_W-1:0]   tail_ff [NUM_CLASSES];
   logic [PTR_W-1:0]   tail_in [NUM_CLASSES];
   logic [CNT_W-1:0]   cnt_ff  [NUM_CLASSES];
   logic [CNT_W-1:0]   cnt_in  [NUM_CLASSES];
   logic [CNT_W-1:0]   occ_ff, occ_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // List walk and read tracking.
   cls_idx_type        rd_cls_ff, rd_cls_in;
   cls_idx_type        walk_cls_ff, walk_cls_in;
   logic [PTR_W-1:0]   walk_ptr_ff, walk_ptr_in;
   logic [CNT_W-1:0]   walk_left_ff, walk_left_in;
   logic [CNT_W-1:0]   walk_total_ff, walk_total_in;

   // Response payload.
   status_type         rsp_status_ff, rsp_status_in;
   logic [FIELD_ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic [CLASS_W-1:0] rsp_class_ff, rsp_class_in;
   logic               rsp_last_ff, rsp_last_in;

   // Memory port.
   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic [ID_W-1:0]    mem_rd_data;

   // Request decode.
   req_kind_type       in_kind;
   logic [ID_W-1:0]    in_id;
   cls_idx_type        in_cidx;
   cls_idx_type        first_cidx;
   cls_idx_type        after_cidx;
   logic               out_free;
   logic               accept;

   assign in_kind = req_kind_type'(req_tuser);
   assign in_id   = ID_W'(req_tdata[FIELD_ID_W-1:0]);
   assign in_cidx = class_to_idx(req_tdata[FIELD_ID_W+CLASS_W-1:FIELD_ID_W]);

   // Head of the queue lives in the first nonempty region.
   assign first_cidx = (cnt_ff[0] != '0) ? cls_idx_type'(0) :
                       (cnt_ff[1] != '0) ? cls_idx_type'(1) : cls_idx_type'(2);
   // Next nonempty region after the one being walked; one always exists here.
   assign after_cidx = (walk_cls_ff == cls_idx_type'(0) && cnt_ff[1] != '0) ?
                       cls_idx_type'(1) : cls_idx_type'(2);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   tcspq_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (ID_W),
      .DEPTH  (MEM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (in_id),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cnt_in        = cnt_ff;
      occ_in        = occ_ff;
      rd_cls_in     = rd_cls_ff;
      walk_cls_in   = walk_cls_ff;
      walk_ptr_in   = walk_ptr_ff;
      walk_left_in  = walk_left_ff;
      walk_total_in = walk_total_ff;
      // Drop the response once taken; hold it otherwise.
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_class_in  = rsp_class_ff;
      rsp_last_in   = rsp_last_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // Status-only responses carry no entry and close the request.
               rsp_valid_in = 1'b1;
               rsp_id_in    = '0;
               rsp_class_in = NO_CLASS;
               rsp_last_in  = 1'b1;
               case (in_kind)
                  REQ_ENQUEUE: begin
                     if (occ_ff == CNT_FULL) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        // Append to the tail of the entry's class region.
                        mem_wr_en        = 1'b1;
                        mem_wr_addr      = {in_cidx, tail_ff[in_cidx]};
                        tail_in[in_cidx] = ptr_next(tail_ff[in_cidx]);
                        cnt_in[in_cidx]  = cnt_ff[in_cidx] + 1'b1;
                        occ_in           = occ_ff + 1'b1;
                        rsp_status_in    = STS_ACCEPTED;
                     end
                  end
                  REQ_DEQUEUE: begin
                     if (occ_ff == '0) begin
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        // Pop the head now; the identifier arrives next cycle.
                        rsp_valid_in        = 1'b0;
                        mem_rd_en           = 1'b1;
                        mem_rd_addr         = {first_cidx, head_ff[first_cidx]};
                        head_in[first_cidx] = ptr_next(head_ff[first_cidx]);
                        cnt_in[first_cidx]  = cnt_ff[first_cidx] - 1'b1;
                        occ_in              = occ_ff - 1'b1;
                        rd_cls_in           = first_cidx;
                        state_in            = S_SERVE;
                     end
                  end
                  REQ_LIST: begin
                     if (occ_ff == '0) begin
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        // Start the walk at the head of the first nonempty region.
                        rsp_valid_in  = 1'b0;
                        mem_rd_en     = 1'b1;
                        mem_rd_addr   = {first_cidx, head_ff[first_cidx]};
                        rd_cls_in     = first_cidx;
                        walk_cls_in   = first_cidx;
                        walk_ptr_in   = ptr_next(head_ff[first_cidx]);
                        walk_left_in  = cnt_ff[first_cidx];
                        walk_total_in = occ_ff;
                        state_in      = S_LIST;
                     end
                  end
                  default: begin
                     rsp_status_in = STS_INVALID;
                  end
               endcase
            end
         end

         S_SERVE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_SERVED;
               rsp_id_in     = FIELD_ID_W'(mem_rd_data);
               rsp_class_in  = idx_to_class(rd_cls_ff);
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         S_LIST: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_LISTED;
               rsp_id_in     = FIELD_ID_W'(mem_rd_data);
               rsp_class_in  = idx_to_class(rd_cls_ff);
               rsp_last_in   = (walk_total_ff == CNT_ONE);
               if (walk_total_ff == CNT_ONE) begin
                  state_in = S_IDLE;
               end else begin
                  walk_total_in = walk_total_ff - 1'b1;
                  mem_rd_en     = 1'b1;
                  if (walk_left_ff == CNT_ONE) begin
                     // Region done: hop to the head of the next nonempty one.
                     mem_rd_addr  = {after_cidx, head_ff[after_cidx]};
                     rd_cls_in    = after_cidx;
                     walk_cls_in  = after_cidx;
                     walk_ptr_in  = ptr_next(head_ff[after_cidx]);
                     walk_left_in = cnt_ff[after_cidx];
                  end else begin
                     mem_rd_addr  = {walk_cls_ff, walk_ptr_ff};
                     rd_cls_in    = walk_cls_ff;
                     walk_ptr_in  = ptr_next(walk_ptr_ff);
                     walk_left_in = walk_left_ff - 1'b1;
                  end
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         occ_ff        <= '0;
         head_ff       <= '{default: '0};
         tail_ff       <= '{default: '0};
         cnt_ff        <= '{default: '0};
         rd_cls_ff     <= '0;
         walk_cls_ff   <= '0;
         walk_ptr_ff   <= '0;
         walk_left_ff  <= '0;
         walk_total_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         occ_ff        <= occ_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         cnt_ff        <= cnt_in;
         rd_cls_ff     <= rd_cls_in;
         walk_cls_ff   <= walk_cls_in;
         walk_ptr_ff   <= walk_ptr_in;
         walk_left_ff  <= walk_left_in;
         walk_total_ff <= walk_total_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_class_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   `TCSPQ_ASSERT_IMP(a_occ_bound, clock, reset, 1'b1, occ_ff <= CNT_FULL, "occupancy above depth")
   `TCSPQ_ASSERT_IMP(a_occ_sum, clock, reset, 1'b1, occ_ff == cnt_ff[0] + cnt_ff[1] + cnt_ff[2], "class counts disagree with occupancy")
   `TCSPQ_ASSERT_IMP(a_no_write_busy, clock, reset, state_ff != S_IDLE, !mem_wr_en, "memory write during a read walk")
   `TCSPQ_ASSERT_NEXT(a_enq_grows, clock, reset, accept && in_kind == REQ_ENQUEUE && occ_ff != CNT_FULL, occ_ff == $past(occ_ff) + 1'b1, "accepted enqueue did not grow the queue")

endmodule
`default_nettype wire

>>> test/three_class_stable_priority_queue_test.sv
// Self-checking testbench for the three-class stable priority queue.
`timescale 1ns / 1ps
module three_class_stable_priority_queue_test;
   import tcspq_pkg::*;

   localparam int DEPTH       = DEFAULT_QUEUE_DEPTH;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int DRAIN_WAIT  = 40;
   localparam int BLOCK_COUNT = 12;
   localparam int BLOCK_ITEMS = 40;

   // Bias of the random request mix for one block of traffic.
   typedef enum logic [1:0] {
      MODE_FILL,
      MODE_DRAIN,
      MODE_MIXED
   } traffic_mode_type;

   // One response as the queue should present it.
   typedef struct packed {
      status_type         status;
      logic [15:0]        id;
      logic [CLASS_W-1:0] cls;
      logic               last;
   } response_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [TDATA_W-1:0]     req_tdata = '0;     // [15:0] entry_id, [17:16] entry_class
   logic [REQ_TYPE_W-1:0]  req_tuser = REQ_INVALID; // [1:0] req_type
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [TDATA_W-1:0]     rsp_tdata;          // [15:0] out_id, [17:16] out_class
   logic [STATUS_W-1:0]    rsp_tuser;          // [2:0] status
   logic                   rsp_tlast;

   // Shadow of the queue contents, head at index 0.
   logic [15:0]        shadow_ids [DEPTH];
   logic [CLASS_W-1:0] shadow_classes [DEPTH];
   int                 shadow_count = 0;

   response_type pending_responses [$];
   int           error_count = 0;
   int           cycle_count = 0;
   int           stall_left = 0;
   bit           steady_flow = 1'b0;

   three_class_stable_priority_queue #(
      .QUEUE_DEPTH (DEPTH),
      .ID_BITS     (DEFAULT_ID_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 0;
   end

   // Hard stop in case the queue hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Mostly short idle stretches, now and then a long one.
   function automatic int pick_idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void queue_response(status_type status, logic [15:0] id,
                                          logic [CLASS_W-1:0] cls, logic last);
      response_type r;
      r.status = status;
      r.id     = id;
      r.cls    = cls;
      r.last   = last;
      pending_responses.push_back(r);
   endfunction

   // Apply one accepted request to the shadow queue and queue its responses.
   function automatic void predict_responses(req_kind_type kind, logic [15:0] id,
                                             logic [CLASS_W-1:0] cls);
      int                 pos;
      int                 i;
      logic [CLASS_W-1:0] rank;
      case (kind)
         REQ_ENQUEUE: begin
            if (shadow_count >= DEPTH) begin
               queue_response(STS_FULL, '0, NO_CLASS, 1'b1);
            end else begin
               // An unknown class ranks with the lowest one.
               rank = (cls == NO_CLASS) ? LOWEST_CLASS : cls;
               pos = 0;
               // Skip every entry of equal or better class to keep FIFO order.
               while (pos < shadow_count && shadow_classes[pos] <= rank) pos++;
               for (i = shadow_count; i > pos; i--) begin
                  shadow_ids[i]     = shadow_ids[i - 1];
                  shadow_classes[i] = shadow_classes[i - 1];
               end
               shadow_ids[pos]     = id;
               shadow_classes[pos] = rank;
               shadow_count++;
               queue_response(STS_ACCEPTED, '0, NO_CLASS, 1'b1);
            end
         end
         REQ_DEQUEUE: begin
            if (shadow_count == 0) begin
               queue_response(STS_EMPTY, '0, NO_CLASS, 1'b1);
            end else begin
               queue_response(STS_SERVED, shadow_ids[0], shadow_classes[0], 1'b1);
               for (i = 1; i < shadow_count; i++) begin
                  shadow_ids[i - 1]     = shadow_ids[i];
                  shadow_classes[i - 1] = shadow_classes[i];
               end
               shadow_count--;
            end
         end
         REQ_LIST: begin
            if (shadow_count == 0) begin
               queue_response(STS_EMPTY, '0, NO_CLASS, 1'b1);
            end else begin
               for (i = 0; i < shadow_count; i++)
                  queue_response(STS_LISTED, shadow_ids[i], shadow_classes[i],
                                 i == shadow_count - 1);
            end
         end
         default: begin
            queue_response(STS_INVALID, '0, NO_CLASS, 1'b1);
         end
      endcase
   endfunction

   // Present one request and hold it until the queue takes it. Valid is left high
   // afterwards so back-to-back requests need no second assignment in one step.
   task automatic send_request(req_kind_type kind, logic [15:0] id,
                               logic [CLASS_W-1:0] cls);
      int gap;
      gap = steady_flow ? 0 : pick_idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(TDATA_W - 18){1'b0}}, cls, id};
      req_tuser  <= kind;
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_responses(kind, id, cls);
   endtask

   // Receiver side: stall rsp_tready at random unless traffic runs steady.
   always @(posedge clock) begin
      if (reset || steady_flow) begin
         rsp_tready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         stall_left = pick_idle_length();
         rsp_tready <= (stall_left == 0);
         if (stall_left > 0) stall_left--;
      end
   end

   function automatic void compare_field(string label, logic [15:0] want,
                                         logic [15:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h",
                  $time, label, want, got);
      end
   endfunction

   // Check each response that leaves the queue against the oldest prediction.
   always @(posedge clock) begin : check_response
      response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_responses.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response, expected none, actual status %0d id %0h",
                     $time, rsp_tuser, rsp_tdata[15:0]);
         end else begin
            want = pending_responses.pop_front();
            compare_field("status", 16'(want.status), 16'(rsp_tuser));
            compare_field("out_id", want.id, rsp_tdata[15:0]);
            compare_field("out_class", 16'(want.cls), 16'(rsp_tdata[17:16]));
            compare_field("last", 16'(want.last), 16'(rsp_tlast));
            compare_field("tdata padding", 16'h0, 16'(rsp_tdata[TDATA_W-1:18]));
         end
      end
   end

   // Empty queue: dequeue and list report empty, an unknown request is invalid.
   task automatic test_empty_queue();
      send_request(REQ_DEQUEUE, 16'h0000, NO_CLASS);
      send_request(REQ_LIST, 16'hFFFF, LOWEST_CLASS);
      send_request(REQ_INVALID, 16'hFFFF, LOWEST_CLASS);
   endtask

   // Fill with every class including class zero and the id extremes, overflow
   // once, then list the full queue and poke it with an invalid request.
   task automatic test_fill_and_overflow();
      int i;
      for (i = 0; i < DEPTH; i++) begin
         case (i % 4)
            0: send_request(REQ_ENQUEUE, 16'hFFFF, LOWEST_CLASS);
            1: send_request(REQ_ENQUEUE, 16'h0000, VIP);
            2: send_request(REQ_ENQUEUE, 16'(16'hA5C3 + i), 2'd2);
            default: send_request(REQ_ENQUEUE, 16'(16'h5A3C - i), NO_CLASS);
         endcase
      end
      send_request(REQ_ENQUEUE, 16'h1234, VIP);
      send_request(REQ_LIST, 16'h0000, NO_CLASS);
      send_request(REQ_INVALID, 16'h0000, NO_CLASS);
   endtask

   // Serve from the head: class 1 entries leave first, in arrival order.
   task automatic test_serve_head();
      send_request(REQ_DEQUEUE, 16'hFFFF, VIP);
      send_request(REQ_DEQUEUE, 16'h0000, LOWEST_CLASS);
   endtask

   function automatic req_kind_type pick_kind(traffic_mode_type mode);
      int roll;
      int enq_cut;
      int deq_cut;
      int list_cut;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_FILL:  begin enq_cut = 75; deq_cut = 85; list_cut = 95; end
         MODE_DRAIN: begin enq_cut = 20; deq_cut = 80; list_cut = 92; end
         default:    begin enq_cut = 45; deq_cut = 80; list_cut = 93; end
      endcase
      if (roll < enq_cut) return REQ_ENQUEUE;
      if (roll < deq_cut) return REQ_DEQUEUE;
      if (roll < list_cut) return REQ_LIST;
      return REQ_INVALID;
   endfunction

   // Blocks that push toward full, drain toward empty or mix; every fourth block
   // runs with no idling on either side.
   task automatic test_random_traffic();
      int                 blk;
      int                 n;
      int                 roll;
      logic [15:0]        id;
      logic [CLASS_W-1:0] cls;
      for (blk = 0; blk < BLOCK_COUNT; blk++) begin
         steady_flow = (blk % 4 == 3);
         for (n = 0; n < BLOCK_ITEMS; n++) begin
            roll = $urandom_range(0, 9);
            id   = (roll == 0) ? 16'h0000 : (roll == 1) ? 16'hFFFF : 16'($urandom);
            cls  = ($urandom_range(0, 7) == 0) ? NO_CLASS : CLASS_W'($urandom_range(1, 3));
            send_request(pick_kind(traffic_mode_type'(blk % 3)), id, cls);
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_queue();
      test_fill_and_overflow();
      test_serve_head();
      test_random_traffic();

      // Drop valid once the last request is in, then drain the responses.
      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/tcspq_pkg.sv
hdl/tcspq_ram.sv
hdl/three_class_stable_priority_queue.sv
test/three_class_stable_priority_queue_test.sv
